### rtl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`endif

### rtl/lcdx_pkg.sv
// Shared types, codes and the start-up step table of the LCD expander sequencer
package lcdx_pkg;

  typedef enum logic [1:0] {
    OP_STARTUP = 2'd0,
    OP_COMMAND = 2'd1,
    OP_DATA    = 2'd2,
    OP_CURSOR  = 2'd3
  } op_e;

  typedef enum logic {
    FRONT_IDLE,
    FRONT_EMIT
  } front_state_e;

  // One queued step: a nibble write (three expander bytes) or a wait
  typedef struct packed {
    logic       is_wait;
    logic [7:0] data;     // nibble in bits 7..4, or wait length in ms
    logic       rs;
    logic       last;
  } step_t;

  localparam logic [7:0] LCD_BACKLIGHT = 8'h08;
  localparam logic [7:0] LCD_ENABLE    = 8'h04;
  localparam logic [7:0] LCD_RS        = 8'h01;
  localparam logic [7:0] CURSOR_CMD    = 8'h80;
  localparam logic [7:0] CURSOR_WAIT   = 8'd3;
  localparam logic [7:0] ADDR_RESET    = 8'd78;

  localparam int unsigned STEP_FIFO_DEPTH = 4;
  localparam int unsigned STEP_PTR_W      = $clog2(STEP_FIFO_DEPTH);
  localparam int unsigned STEP_CNT_W      = $clog2(STEP_FIFO_DEPTH + 1);

  localparam int unsigned STEP_IDX_W      = 5;

  function automatic step_t mk_step(logic w, logic [7:0] d, logic l);
    step_t s;
    s.is_wait = w;
    s.data    = d;
    s.rs      = 1'b0;
    s.last    = l;
    return s;
  endfunction

  // Start-up: 8-bit function set three times, switch to 4-bit, then four commands
  function automatic step_t startup_step(logic [STEP_IDX_W-1:0] idx);
    step_t s;
    unique case (idx)
      5'd0:    s = mk_step(1'b1, 8'd20, 1'b0);
      5'd1:    s = mk_step(1'b0, 8'h30, 1'b0);
      5'd2:    s = mk_step(1'b1, 8'd5,  1'b0);
      5'd3:    s = mk_step(1'b0, 8'h30, 1'b0);
      5'd4:    s = mk_step(1'b1, 8'd1,  1'b0);
      5'd5:    s = mk_step(1'b0, 8'h30, 1'b0);
      5'd6:    s = mk_step(1'b0, 8'h20, 1'b0);
      5'd7:    s = mk_step(1'b1, 8'd10, 1'b0);
      5'd8:    s = mk_step(1'b0, 8'h20, 1'b0);
      5'd9:    s = mk_step(1'b0, 8'h80, 1'b0);
      5'd10:   s = mk_step(1'b1, 8'd1,  1'b0);
      5'd11:   s = mk_step(1'b0, 8'h00, 1'b0);
      5'd12:   s = mk_step(1'b0, 8'hC0, 1'b0);
      5'd13:   s = mk_step(1'b1, 8'd10, 1'b0);
      5'd14:   s = mk_step(1'b0, 8'h00, 1'b0);
      5'd15:   s = mk_step(1'b0, 8'h10, 1'b0);
      5'd16:   s = mk_step(1'b1, 8'd10, 1'b0);
      5'd17:   s = mk_step(1'b0, 8'h00, 1'b0);
      5'd18:   s = mk_step(1'b0, 8'h60, 1'b1);
      default: s = mk_step(1'b1, 8'd0,  1'b1);
    endcase
    return s;
  endfunction

endpackage

### rtl/lcdx_front.sv
// Front end: accepts requests and breaks them into nibble and wait steps
module lcdx_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  logic [1:0]          req_op_i,
  input  logic [7:0]          req_value_i,
  output logic                push_o,
  output lcdx_pkg::step_t     push_step_o,
  input  logic                full_i
);
  import lcdx_pkg::*;

  front_state_e           state_q, state_d;
  op_e                    op_q;
  logic [7:0]             val_q;
  logic [STEP_IDX_W-1:0]  idx_q, idx_d;
  logic [7:0]             cmd_byte;
  step_t                  step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FRONT_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) begin
      op_q  <= op_e'(req_op_i);
      val_q <= req_value_i;
    end
  end

  assign cmd_byte = (op_q == OP_CURSOR) ? (CURSOR_CMD | val_q) : val_q;

  always_comb begin
    step = mk_step(1'b1, CURSOR_WAIT, 1'b1);
    unique case (op_q) inside
      OP_STARTUP: step = startup_step(idx_q);
      OP_COMMAND, OP_DATA, OP_CURSOR: begin
        if (idx_q == STEP_IDX_W'(0)) begin
          step = mk_step(1'b0, {cmd_byte[7:4], 4'b0000}, 1'b0);
        end else if (idx_q == STEP_IDX_W'(1)) begin
          step = mk_step(1'b0, {cmd_byte[3:0], 4'b0000}, op_q != OP_CURSOR);
        end
        step.rs = (op_q == OP_DATA);
      end
      default: step = mk_step(1'b1, CURSOR_WAIT, 1'b1);
    endcase
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    req_ready_o = 1'b0;
    push_o      = 1'b0;
    push_step_o = step;
    unique case (state_q)
      FRONT_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          state_d = FRONT_EMIT;
          idx_d   = '0;
        end
      end
      FRONT_EMIT: begin
        if (!full_i) begin
          push_o = 1'b1;
          idx_d  = idx_q + STEP_IDX_W'(1);
          if (step.last) begin
            state_d = FRONT_IDLE;
          end
        end
      end
      default: state_d = FRONT_IDLE;
    endcase
  end

endmodule

### rtl/lcdx_step_fifo.sv
// Short step queue between the front end and the byte generator
module lcdx_step_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lcdx_pkg::step_t push_step_i,
  output logic            full_o,
  input  logic            pop_i,
  output lcdx_pkg::step_t head_o,
  output logic            empty_o
);
  import lcdx_pkg::*;

  step_t                  mem_q [STEP_FIFO_DEPTH];
  logic [STEP_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [STEP_CNT_W-1:0]  count_q;
  logic                   do_push, do_pop;

  assign full_o  = (count_q == STEP_CNT_W'(STEP_FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + STEP_PTR_W'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + STEP_PTR_W'(1);
      if (do_push && !do_pop) begin
        count_q <= count_q + STEP_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - STEP_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_step_i;
  end

endmodule

### rtl/lcdx_back.sv
// Back end: steps to expander bytes and waits, one result a cycle unless stalled
module lcdx_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lcdx_pkg::step_t head_i,
  input  logic            empty_i,
  output logic            pop_o,
  input  logic [7:0]      bus_addr_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output logic [15:0]     res_data_o,
  output logic            res_kind_o,
  output logic            res_last_o
);
  import lcdx_pkg::*;

  logic [1:0] phase_q;
  logic       valid_q;
  logic       kind_q, last_q;
  logic [7:0] payload_q, addr_q;
  logic       load;
  logic       step_done;
  logic [7:0] byte_val;

  // Output register can take a new result when empty or being drained
  assign load      = !empty_i && (!valid_q || res_ready_i);
  assign step_done = head_i.is_wait || (phase_q == 2'd2);
  assign pop_o     = load && step_done;

  // Enable is high only on the middle byte of a nibble
  assign byte_val = {head_i.data[7:4], 4'b0000} | LCD_BACKLIGHT
                  | ((phase_q == 2'd1) ? LCD_ENABLE : 8'h00)
                  | (head_i.rs ? LCD_RS : 8'h00);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        phase_q <= step_done ? 2'd0 : phase_q + 2'd1;
      end else if (res_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q    <= head_i.is_wait;
      payload_q <= head_i.is_wait ? head_i.data : byte_val;
      addr_q    <= head_i.is_wait ? 8'h00 : bus_addr_i;
      last_q    <= head_i.last && step_done;
    end
  end

  assign res_valid_o = valid_q;
  assign res_data_o  = {addr_q, payload_q};
  assign res_kind_o  = kind_q;
  assign res_last_o  = last_q;

endmodule

### rtl/char_lcd_expander_sequencer.sv
// Top level of the character LCD expander sequencer: front end, step queue, back end
//
// Slave stream: one request per transfer. s_axis_tuser selects the operation
// (start-up, command byte, data byte, cursor position), s_axis_tdata holds the
// byte. Master stream: one result per transfer, an expander byte (tuser 0) with
// its bus address, or a wait in milliseconds (tuser 1, address 0); tlast marks
// the final result of a request.
// cfg_we_i writes the expander address; write it only while the block is idle.
// The front end registers a request; the back end registers each result and gives
// one result a cycle while the receiver takes them, 6 results for a command or data
// request, 7 for a cursor request and 43 for start-up. The front end takes one
// request at a time and refills the step queue as it drains.
// Reset empties the queue and output register and sets the address to 78.
// When the receiver stalls the output register holds and the queue fills; an
// idle front end still takes one more request, then holds it and
// s_axis_tready stays low until the queue drains.
module char_lcd_expander_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] value
  input  logic [1:0]  s_axis_tuser,   // [1:0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] payload, [15:8] bus_address
  output logic [0:0]  m_axis_tuser,   // [0] kind
  output logic        m_axis_tlast
);
  import lcdx_pkg::*;

  logic       addr_cfg_q;
  logic [7:0] exp_addr_q;
  logic       push, full, pop, empty;
  step_t      push_step, head;
  logic       kind;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_addr_q <= ADDR_RESET;
      addr_cfg_q <= 1'b0;
    end else if (cfg_we_i) begin
      exp_addr_q <= cfg_wdata_i;
      addr_cfg_q <= 1'b1;
    end
  end

  lcdx_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_op_i    (s_axis_tuser),
    .req_value_i (s_axis_tdata),
    .push_o      (push),
    .push_step_o (push_step),
    .full_i      (full)
  );

  lcdx_step_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_step_i (push_step),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  lcdx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .bus_addr_i  (addr_cfg_q ? exp_addr_q : ADDR_RESET),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_data_o  (m_axis_tdata),
    .res_kind_o  (kind),
    .res_last_o  (m_axis_tlast)
  );

  assign m_axis_tuser = kind;

endmodule

### rtl/lcdx_checker.sv
// Port-level checker for the LCD expander sequencer, bound to the top level
`include "assert_macros.svh"

module lcdx_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

  `ASSERT_NEVER(a_wait_addr, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0] && m_axis_tdata[15:8] != 8'h00, "wait result carries an address")

  `ASSERT_NEVER(a_backlight, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[0] && !m_axis_tdata[3], "expander byte without backlight")

  `ASSERT_NEVER(a_strobe_last, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[0] && m_axis_tdata[2] && m_axis_tlast, "request ends with enable high")

endmodule

bind char_lcd_expander_sequencer lcdx_checker u_lcdx_checker (.*);
